// File: rtl/fd16_pkg.sv
`timescale 1ns / 1ps

package fd16_pkg;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'h1021;
   localparam logic [15:0] POS_MAX  = 16'hFFFF;
   localparam int HDR_BYTES  = 8;
   localparam int CRC_BYTES  = 2;
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [2:0] {
      CSR_MAGIC_FIRST      = 3'd0,
      CSR_MAGIC_SECOND     = 3'd1,
      CSR_PROTOCOL_VERSION = 3'd2,
      CSR_LOWEST_KIND      = 3'd3,
      CSR_HIGHEST_KIND     = 3'd4,
      CSR_FAULT_KIND       = 3'd5,
      CSR_MAX_PAYLOAD_LEN  = 3'd6
   } csr_index_type;

   typedef enum logic [2:0] {
      HDR_MAGIC_FIRST  = 3'd0,
      HDR_MAGIC_SECOND = 3'd1,
      HDR_VERSION      = 3'd2,
      HDR_KIND         = 3'd3,
      HDR_SEQ_LO       = 3'd4,
      HDR_SEQ_HI       = 3'd5,
      HDR_LEN_LO       = 3'd6,
      HDR_LEN_HI       = 3'd7
   } hdr_field_type;

   typedef enum logic [2:0] {
      FAULT_LENGTH   = 3'd0,
      FAULT_MAGIC    = 3'd1,
      FAULT_CHECKSUM = 3'd2,
      FAULT_VERSION  = 3'd3,
      FAULT_KIND     = 3'd4,
      FAULT_SEQUENCE = 3'd5
   } fault_type;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [7:0]  echo_byte;
      logic        is_payload;
      logic        frame_done;
      logic        frame_ok;
      fault_type   fault_code;
      logic [7:0]  message_kind;
      logic [15:0] sequence_number;
      logic [15:0] payload_length;
   } rsp_type;

   typedef struct packed {
      logic [7:0]  magic_first;
      logic [7:0]  magic_second;
      logic [7:0]  protocol_version;
      logic [7:0]  lowest_kind;
      logic [7:0]  highest_kind;
      logic [7:0]  fault_kind;
      logic [15:0] max_payload_length;
   } cfg_type;

   typedef struct packed {
      logic [7:0]    frame_byte;
      logic          last;
      logic          payload;
      logic          crc_update;
      logic          rcrc_lo;
      logic          rcrc_hi;
      logic          hdr;
      hdr_field_type hdr_field;
      logic          kind_valid;
      logic          seq_valid;
      logic          short_frame;
      logic          len_bad;
      logic [15:0]   length;
   } entry_type;

   function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {b, 8'h00};
      for (int i = 0; i < 8; i++) begin
         c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
      end
      return c;
   endfunction

endpackage

// File: rtl/fd16_csr.sv
`timescale 1ns / 1ps

module fd16_csr import fd16_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata,
   output cfg_type       cfg
);

   cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_MAGIC_FIRST:      cfg_in.magic_first        = csr_wdata[7:0];
            CSR_MAGIC_SECOND:     cfg_in.magic_second       = csr_wdata[7:0];
            CSR_PROTOCOL_VERSION: cfg_in.protocol_version   = csr_wdata[7:0];
            CSR_LOWEST_KIND:      cfg_in.lowest_kind        = csr_wdata[7:0];
            CSR_HIGHEST_KIND:     cfg_in.highest_kind       = csr_wdata[7:0];
            CSR_FAULT_KIND:       cfg_in.fault_kind         = csr_wdata[7:0];
            CSR_MAX_PAYLOAD_LEN:  cfg_in.max_payload_length = csr_wdata;
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.magic_first        <= 8'd0;
         cfg_ff.magic_second       <= 8'd0;
         cfg_ff.protocol_version   <= 8'd1;
         cfg_ff.lowest_kind        <= 8'd1;
         cfg_ff.highest_kind       <= 8'd255;
         cfg_ff.fault_kind         <= 8'd0;
         cfg_ff.max_payload_length <= 16'd64;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: rtl/fd16_front.sv
`timescale 1ns / 1ps

module fd16_front import fd16_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        accept,
   input  req_type     req_data,
   input  logic [15:0] max_payload_length,
   output entry_type   entry
);

   logic [15:0] pos_ff, pos_in;
   logic [15:0] len_ff, len_in;
   logic [15:0] len_new;
   logic [16:0] body_end;
   logic [16:0] count;
   logic [16:0] want;
   logic        overflow;

   always_comb begin
      body_end = 17'(HDR_BYTES) + {1'b0, len_ff};
      len_new  = len_ff;
      if (pos_ff == 16'(HDR_BYTES - 2)) len_new[7:0]  = req_data.frame_byte;
      if (pos_ff == 16'(HDR_BYTES - 1)) len_new[15:8] = req_data.frame_byte;
      count    = {1'b0, pos_ff} + 17'd1;
      want     = 17'(HDR_BYTES + CRC_BYTES) + {1'b0, len_new};
      overflow = (pos_ff == POS_MAX);

      entry.frame_byte  = req_data.frame_byte;
      entry.last        = req_data.last_byte;
      entry.hdr         = pos_ff < 16'(HDR_BYTES);
      entry.hdr_field   = hdr_field_type'(pos_ff[2:0]);
      entry.payload     = !entry.hdr && ({1'b0, pos_ff} < body_end);
      entry.crc_update  = entry.hdr || ({1'b0, pos_ff} < body_end);
      entry.rcrc_lo     = !entry.crc_update && ({1'b0, pos_ff} == body_end);
      entry.rcrc_hi     = !entry.crc_update && ({1'b0, pos_ff} == body_end + 17'd1);
      entry.kind_valid  = count >= 17'd4;
      entry.seq_valid   = count >= 17'd6;
      entry.short_frame = !overflow && (count < 17'(HDR_BYTES + CRC_BYTES));
      entry.len_bad     = overflow || (len_new > max_payload_length) || (count != want);
      entry.length      = len_new;
   end

   always_comb begin
      pos_in = pos_ff;
      len_in = len_ff;
      if (accept) begin
         if (req_data.last_byte) begin
            pos_in = 16'd0;
            len_in = 16'd0;
         end else begin
            len_in = len_new;
            if (!overflow) pos_in = pos_ff + 16'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 16'd0;
         len_ff <= 16'd0;
      end else begin
         pos_ff <= pos_in;
         len_ff <= len_in;
      end
   end

endmodule

// File: rtl/fd16_fifo.sv
`timescale 1ns / 1ps

module fd16_fifo import fd16_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      wr_en,
   input  entry_type wr_data,
   output logic      full,
   input  logic      rd_en,
   output logic      rd_valid,
   output entry_type rd_data
);

   entry_type            mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_wr, do_rd;

   assign full     = (count_ff == (FIFO_AW + 1)'(FIFO_DEPTH));
   assign rd_valid = (count_ff != '0);
   assign rd_data  = mem_ff[rd_ptr_ff];
   assign do_wr    = wr_en && !full;
   assign do_rd    = rd_en && rd_valid;

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + FIFO_AW'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + FIFO_AW'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) count_in = count_ff + (FIFO_AW + 1)'(1);
      if (!do_wr && do_rd) count_in = count_ff - (FIFO_AW + 1)'(1);
   end

   always_ff @(posedge clock) begin
      if (do_wr) mem_ff[wr_ptr_ff] <= wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/fd16_back.sv
`timescale 1ns / 1ps

module fd16_back import fd16_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      q_valid,
   input  entry_type q_data,
   output logic      q_pop,
   output logic      rsp_empty,
   input  logic      rsp_pop,
   output rsp_type   rsp_data
);

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_ff, rsp_in;
   logic [15:0] crc_ff, crc_in, crc_new;
   logic        magic_ff, magic_in, magic_new;
   logic [7:0]  version_ff, version_in, version_new;
   logic [7:0]  kind_ff, kind_in, kind_new;
   logic [15:0] seq_ff, seq_in, seq_new;
   logic [15:0] rcrc_ff, rcrc_in, rcrc_new;
   logic [7:0]  kind_out;
   logic [15:0] seq_out;
   fault_type   fault;
   logic        ok;

   assign q_pop     = q_valid && (!rsp_valid_ff || rsp_pop);
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      magic_new   = magic_ff;
      version_new = version_ff;
      kind_new    = kind_ff;
      seq_new     = seq_ff;
      if (q_data.hdr) begin
         case (q_data.hdr_field)
            HDR_MAGIC_FIRST:  if (q_data.frame_byte != cfg.magic_first) magic_new = 1'b0;
            HDR_MAGIC_SECOND: if (q_data.frame_byte != cfg.magic_second) magic_new = 1'b0;
            HDR_VERSION:      version_new = q_data.frame_byte;
            HDR_KIND:         kind_new = q_data.frame_byte;
            HDR_SEQ_LO:       seq_new[7:0] = q_data.frame_byte;
            HDR_SEQ_HI:       seq_new[15:8] = q_data.frame_byte;
            default:          magic_new = magic_ff;
         endcase
      end
      crc_new  = q_data.crc_update ? crc16_byte(crc_ff, q_data.frame_byte) : crc_ff;
      rcrc_new = rcrc_ff;
      if (q_data.rcrc_lo) rcrc_new[7:0]  = q_data.frame_byte;
      if (q_data.rcrc_hi) rcrc_new[15:8] = q_data.frame_byte;
   end

   always_comb begin
      kind_out = q_data.kind_valid ? kind_new : 8'd0;
      seq_out  = q_data.seq_valid ? seq_new : 16'd0;
      fault    = FAULT_LENGTH;
      ok       = 1'b0;
      if (q_data.short_frame) begin
         fault = FAULT_LENGTH;
      end else if (!magic_new) begin
         fault    = FAULT_MAGIC;
         kind_out = 8'd0;
         seq_out  = 16'd0;
      end else if (q_data.len_bad) begin
         fault = FAULT_LENGTH;
      end else if (crc_new != rcrc_new) begin
         fault = FAULT_CHECKSUM;
      end else if (version_new != cfg.protocol_version) begin
         fault = FAULT_VERSION;
      end else if (kind_out < cfg.lowest_kind || kind_out > cfg.highest_kind) begin
         fault = FAULT_KIND;
      end else if (seq_out == 16'd0 && kind_out != cfg.fault_kind) begin
         fault = FAULT_SEQUENCE;
      end else begin
         ok = 1'b1;
      end
   end

   always_comb begin
      rsp_in                 = rsp_ff;
      rsp_valid_in           = rsp_valid_ff && !rsp_pop;
      crc_in                 = crc_ff;
      magic_in               = magic_ff;
      version_in             = version_ff;
      kind_in                = kind_ff;
      seq_in                 = seq_ff;
      rcrc_in                = rcrc_ff;
      if (q_pop) begin
         rsp_valid_in           = 1'b1;
         rsp_in.echo_byte       = q_data.frame_byte;
         rsp_in.is_payload      = q_data.payload;
         rsp_in.frame_done      = q_data.last;
         rsp_in.frame_ok        = q_data.last && ok;
         rsp_in.fault_code      = (q_data.last && !ok) ? fault : FAULT_LENGTH;
         rsp_in.message_kind    = q_data.last ? kind_out : 8'd0;
         rsp_in.sequence_number = q_data.last ? seq_out : 16'd0;
         rsp_in.payload_length  = (q_data.last && ok) ? q_data.length : 16'd0;
         if (q_data.last) begin
            crc_in     = CRC_INIT;
            magic_in   = 1'b1;
            version_in = 8'd0;
            kind_in    = 8'd0;
            seq_in     = 16'd0;
            rcrc_in    = 16'd0;
         end else begin
            crc_in     = crc_new;
            magic_in   = magic_new;
            version_in = version_new;
            kind_in    = kind_new;
            seq_in     = seq_new;
            rcrc_in    = rcrc_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         crc_ff       <= CRC_INIT;
         magic_ff     <= 1'b1;
         version_ff   <= 8'd0;
         kind_ff      <= 8'd0;
         seq_ff       <= 16'd0;
         rcrc_ff      <= 16'd0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         crc_ff       <= crc_in;
         magic_ff     <= magic_in;
         version_ff   <= version_in;
         kind_ff      <= kind_in;
         seq_ff       <= seq_in;
         rcrc_ff      <= rcrc_in;
      end
   end

endmodule

// File: rtl/frame_decoder_crc16.sv
`timescale 1ns / 1ps

// Framed packet checker with CRC-16 (poly 0x1021, init 0xFFFF).
// Request side: one frame byte per request, with last_byte on the final byte;
// a request is taken when req_push is high and req_full is low.
// Result side: one result per request, in order; the oldest result sits on
// rsp_data while rsp_empty is low and leaves when rsp_pop is high.
// Every result echoes its byte and marks payload bytes; the result of the last
// byte also carries the verdict, the captured kind, sequence and length.
// Configuration: csr_we writes csr_wdata to register csr_index (magic bytes,
// version, kind range, fault kind, max payload length); other indexes are ignored.
// Each taken request is written into the queue; the back registers its result.
// Throughput: one byte per cycle while results are popped; the front tracks
// position and length, a four-entry queue decouples it from the back, which runs
// the byte-wide CRC and the verdict into a single output register.
// When the receiver stalls the output register holds, the queue fills and
// req_full rises once four requests wait behind the held result.
// Reset clears the frame state, empties the queue and restores the register
// defaults.

module frame_decoder_crc16 import fd16_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_push,
   output logic          req_full,
   input  req_type       req_data,
   output logic          rsp_empty,
   input  logic          rsp_pop,
   output rsp_type       rsp_data,
   input  logic          csr_we,
   input  csr_index_type csr_index,
   input  logic [15:0]   csr_wdata
);

   cfg_type   cfg;
   entry_type front_entry;
   entry_type q_data;
   logic      q_valid;
   logic      q_pop;
   logic      accept;

   assign accept = req_push && !req_full;

   fd16_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   fd16_front u_front (
      .clock              (clock),
      .reset              (reset),
      .accept             (accept),
      .req_data           (req_data),
      .max_payload_length (cfg.max_payload_length),
      .entry              (front_entry)
   );

   fd16_fifo u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (accept),
      .wr_data  (front_entry),
      .full     (req_full),
      .rd_en    (q_pop),
      .rd_valid (q_valid),
      .rd_data  (q_data)
   );

   fd16_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .q_valid   (q_valid),
      .q_data    (q_data),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
